/* src/tlik_pkg.sv */
package tlik_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int TABLE_LEN         = 24;
    localparam int ROOT_BITS         = 24;
    localparam int ROOT_IN_W         = 2 * ROOT_BITS;
    localparam int NORM_IN_W         = 26;
    localparam int CORDIC_W          = 33;
    localparam int ANG_W             = 25;
    localparam int TAB_W             = 22;
    localparam int COMB_W            = 27;

    localparam logic [14:0] MOUNT_HEIGHT_RESET = 15'd512;
    localparam logic [14:0] LINK_LENGTH_RESET  = 15'd1280;

    localparam logic signed [COMB_W-1:0] DEG180_Q16 = 27'sd11796480;
    localparam logic signed [COMB_W-1:0] LIM_BASE   = 27'sd11520;
    localparam logic signed [COMB_W-1:0] LIM_JOINT  = 27'sd23040;

    typedef enum logic [0:0] {
        REG_MOUNT_HEIGHT = 1'b0,
        REG_LINK_LENGTH  = 1'b1
    } t_cfg_reg;

    // sideband through the square root pipeline
    typedef struct packed {
        logic               valid;
        logic               neg;
        logic               reach;
        logic signed [16:0] bx;
        logic signed [16:0] bz;
        logic signed [16:0] h;
    } t_root_sb;

    // sideband through the base angle CORDIC lane
    typedef struct packed {
        logic valid;
        logic neg;
        logic reach;
    } t_cord_sb;

    // atan(2^-i) in Q.16 degrees, rounded
    function automatic logic [TAB_W-1:0] atan_q16(input int unsigned i);
        logic [TAB_W-1:0] v;
        case (i)
            0:  v = 22'd2949120;
            1:  v = 22'd1740967;
            2:  v = 22'd919879;
            3:  v = 22'd466945;
            4:  v = 22'd234379;
            5:  v = 22'd117304;
            6:  v = 22'd58666;
            7:  v = 22'd29335;
            8:  v = 22'd14668;
            9:  v = 22'd7334;
            10: v = 22'd3667;
            11: v = 22'd1833;
            12: v = 22'd917;
            13: v = 22'd458;
            14: v = 22'd229;
            15: v = 22'd115;
            16: v = 22'd57;
            17: v = 22'd29;
            18: v = 22'd14;
            19: v = 22'd7;
            20: v = 22'd4;
            21: v = 22'd2;
            22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // Q.16 degrees to Q.7 with round half up, then clamp
    function automatic logic signed [15:0] to_q7(input logic signed [COMB_W-1:0] v,
                                                 input logic signed [COMB_W-1:0] lim);
        logic signed [COMB_W-1:0] t;
        t = (v + 27'sd256) >>> 9;
        if (t > lim) begin
            t = lim;
        end else if (t < -lim) begin
            t = -lim;
        end
        return t[15:0];
    endfunction

endpackage

/* src/tlik_if.sv */
interface tlik_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic signed [15:0] target_z;

    modport source (output valid, output target_x, output target_y, output target_z,
                    input ready);
    modport sink   (input valid, input target_x, input target_y, input target_z,
                    output ready);
endinterface

interface tlik_res_if;
    logic               valid;
    logic               ready;
    logic               reachable;
    logic signed [14:0] base_angle;
    logic signed [15:0] shoulder_angle;
    logic signed [15:0] elbow_angle;

    modport source (output valid, output reachable, output base_angle,
                    output shoulder_angle, output elbow_angle, input ready);
    modport sink   (input valid, input reachable, input base_angle,
                    input shoulder_angle, input elbow_angle, output ready);
endinterface

interface tlik_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [14:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/tlik_front.sv */
module tlik_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic signed [15:0]    i_x,
    input  logic signed [15:0]    i_y,
    input  logic signed [15:0]    i_z,
    input  logic [14:0]           i_mount_height,
    input  logic [14:0]           i_link_length,
    output tlik_pkg::t_root_sb    o_sb,
    output logic [tlik_pkg::ROOT_IN_W-1:0] o_num_r,
    output logic [tlik_pkg::ROOT_IN_W-1:0] o_num_d,
    output logic [tlik_pkg::ROOT_IN_W-1:0] o_num_diff
);

    logic signed [16:0] w_x17;
    logic signed [16:0] w_bx;
    logic signed [16:0] w_bz;
    logic signed [16:0] w_h;
    logic               w_neg;
    logic signed [33:0] w_x2;
    logic signed [33:0] w_z2;
    logic signed [33:0] w_h2;
    logic [29:0]        w_l2;

    tlik_pkg::t_root_sb r_s1_sb;
    logic [31:0]        r_s1_x2;
    logic [31:0]        r_s1_z2;
    logic [31:0]        r_s1_h2;
    logic [29:0]        r_s1_l2;

    logic [32:0]        w_r2;
    logic [33:0]        w_d2;
    logic [31:0]        w_reach2;
    logic [31:0]        w_diff;
    tlik_pkg::t_root_sb n_s2_sb;

    tlik_pkg::t_root_sb r_s2_sb;
    logic [31:0]        r_r2;
    logic [31:0]        r_d2;
    logic [31:0]        r_diff;

    // stage 1: fold x to the right half plane, squares
    always_comb begin
        w_x17 = (i_x == 16'sd0) ? 17'sd1 : 17'(i_x);
        w_neg = w_x17[16];
        w_bx  = w_neg ? -w_x17 : w_x17;
        w_bz  = w_neg ? -17'(i_z) : 17'(i_z);
        w_h   = 17'(i_y) - $signed({2'b00, i_mount_height});
        w_x2  = w_bx * w_bx;
        w_z2  = w_bz * w_bz;
        w_h2  = w_h * w_h;
        w_l2  = i_link_length * i_link_length;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_sb <= '0;
        end else if (i_en) begin
            r_s1_sb.valid <= i_valid;
            r_s1_sb.neg   <= w_neg;
            r_s1_sb.reach <= 1'b0;
            r_s1_sb.bx    <= w_bx;
            r_s1_sb.bz    <= w_bz;
            r_s1_sb.h     <= w_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_x2 <= w_x2[31:0];
            r_s1_z2 <= w_z2[31:0];
            r_s1_h2 <= w_h2[31:0];
            r_s1_l2 <= w_l2;
        end
    end

    // stage 2: distances and reach test
    always_comb begin
        w_r2     = {1'b0, r_s1_x2} + {1'b0, r_s1_z2};
        w_d2     = {1'b0, w_r2} + {2'b00, r_s1_h2};
        w_reach2 = {r_s1_l2, 2'b00};
        w_diff   = w_reach2 - w_d2[31:0];
        n_s2_sb       = r_s1_sb;
        n_s2_sb.reach = (w_d2 <= {2'b00, w_reach2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_sb <= '0;
        end else if (i_en) begin
            r_s2_sb <= n_s2_sb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r2   <= w_r2[31:0];
            r_d2   <= w_d2[31:0];
            r_diff <= w_diff;
        end
    end

    assign o_sb       = r_s2_sb;
    assign o_num_r    = {r_r2, 16'h0000};
    assign o_num_d    = {r_d2, 16'h0000};
    assign o_num_diff = {r_diff, 16'h0000};

endmodule

/* src/tlik_root.sv */
module tlik_root (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  tlik_pkg::t_root_sb                  i_sb,
    input  logic [tlik_pkg::ROOT_IN_W-1:0]      i_num_r,
    input  logic [tlik_pkg::ROOT_IN_W-1:0]      i_num_d,
    input  logic [tlik_pkg::ROOT_IN_W-1:0]      i_num_diff,
    output tlik_pkg::t_root_sb                  o_sb,
    output logic [tlik_pkg::ROOT_BITS-1:0]      o_root_r,
    output logic [tlik_pkg::ROOT_BITS-1:0]      o_root_d,
    output logic [tlik_pkg::ROOT_BITS-1:0]      o_root_diff
);

    localparam int RB = tlik_pkg::ROOT_BITS;
    localparam int NW = tlik_pkg::ROOT_IN_W;

    typedef struct packed {
        logic [NW-1:0] num;
        logic [RB+1:0] rem;
        logic [RB-1:0] root;
    } t_lane;

    // one result bit per stage, restoring method
    function automatic t_lane root_step(input t_lane v);
        t_lane         o;
        logic [RB+3:0] rem2;
        logic [RB+3:0] trial;
        rem2  = {v.rem, v.num[NW-1 -: 2]};
        trial = {2'b00, v.root, 2'b01};
        o.num = v.num << 2;
        if (rem2 >= trial) begin
            o.rem  = (RB+2)'(rem2 - trial);
            o.root = {v.root[RB-2:0], 1'b1};
        end else begin
            o.rem  = rem2[RB+1:0];
            o.root = {v.root[RB-2:0], 1'b0};
        end
        return o;
    endfunction

    logic [NW-1:0]      w_num [0:2];
    t_lane              r_ln  [0:RB-1][0:2];
    tlik_pkg::t_root_sb r_sb  [0:RB-1];

    assign w_num[0] = i_num_r;
    assign w_num[1] = i_num_d;
    assign w_num[2] = i_num_diff;

    for (genvar k = 0; k < RB; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sb[0] <= '0;
                end else if (i_en) begin
                    r_sb[0] <= i_sb;
                end
            end
            for (genvar l = 0; l < 3; l++) begin : g_lane
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_ln[0][l] <= root_step('{num: w_num[l], rem: '0, root: '0});
                    end
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sb[k] <= '0;
                end else if (i_en) begin
                    r_sb[k] <= r_sb[k-1];
                end
            end
            for (genvar l = 0; l < 3; l++) begin : g_lane
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_ln[k][l] <= root_step(r_ln[k-1][l]);
                    end
                end
            end
        end
    end

    assign o_sb        = r_sb[RB-1];
    assign o_root_r    = r_ln[RB-1][0].root;
    assign o_root_d    = r_ln[RB-1][1].root;
    assign o_root_diff = r_ln[RB-1][2].root;

endmodule

/* src/tlik_cordic.sv */
module tlik_cordic #(
    parameter int STAGES = tlik_pkg::CORDIC_STAGES_DEF,
    parameter int SB_W   = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic signed [tlik_pkg::NORM_IN_W-1:0] i_x,
    input  logic signed [tlik_pkg::NORM_IN_W-1:0] i_y,
    input  logic [SB_W-1:0]                       i_sb,
    output logic signed [tlik_pkg::ANG_W-1:0]     o_angle,
    output logic [SB_W-1:0]                       o_sb
);

    localparam int CW    = tlik_pkg::CORDIC_W;
    localparam int AW    = tlik_pkg::ANG_W;
    localparam int NROT  = (STAGES > tlik_pkg::TABLE_LEN) ? tlik_pkg::TABLE_LEN : STAGES;
    localparam int NNORM = 5;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] acc;
        logic                 zero;
    } t_cv;

    // double until one magnitude reaches 2^28, in binary steps of s
    function automatic t_cv norm_step(input t_cv v, input int s, input logic last);
        t_cv                  o;
        logic signed [CW-1:0] lim;
        logic                 lo_mag;
        o      = v;
        lim    = CW'(1) << (28 - s);
        lo_mag = (v.x < lim) && (v.x > -lim) && (v.y < lim) && (v.y > -lim);
        if (last) begin
            o.x = lo_mag ? (v.x <<< 2) : (v.x <<< 1);
            o.y = lo_mag ? (v.y <<< 2) : (v.y <<< 1);
        end else if (lo_mag) begin
            o.x = v.x <<< s;
            o.y = v.y <<< s;
        end
        return o;
    endfunction

    function automatic t_cv rot_step(input t_cv v, input int i);
        t_cv                  o;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [AW-1:0] tab;
        o   = v;
        dx  = v.y >>> i;
        dy  = v.x >>> i;
        tab = $signed({{(AW-tlik_pkg::TAB_W){1'b0}}, tlik_pkg::atan_q16(i)});
        if (!v.y[CW-1]) begin
            o.x   = v.x + dx;
            o.y   = v.y - dy;
            o.acc = v.acc + tab;
        end else begin
            o.x   = v.x - dx;
            o.y   = v.y + dy;
            o.acc = v.acc - tab;
        end
        return o;
    endfunction

    t_cv             w_in;
    t_cv             r_n  [0:NNORM-1];
    t_cv             r_c  [0:NROT-1];
    logic [SB_W-1:0] r_sb [0:NNORM+NROT-1];

    always_comb begin
        w_in.x    = CW'(i_x);
        w_in.y    = CW'(i_y);
        w_in.acc  = '0;
        w_in.zero = (i_x == '0) && (i_y == '0);
    end

    for (genvar j = 0; j < NNORM; j++) begin : g_norm
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[0] <= norm_step(w_in, 16, 1'b0);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[j] <= norm_step(r_n[j-1], 16 >> j, (j == NNORM - 1));
                end
            end
        end
    end

    for (genvar i = 0; i < NROT; i++) begin : g_rot
        if (i == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c[0] <= rot_step(r_n[NNORM-1], 0);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c[i] <= rot_step(r_c[i-1], i);
                end
            end
        end
    end

    for (genvar k = 0; k < NNORM + NROT; k++) begin : g_sb
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sb[0] <= '0;
                end else if (i_en) begin
                    r_sb[0] <= i_sb;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sb[k] <= '0;
                end else if (i_en) begin
                    r_sb[k] <= r_sb[k-1];
                end
            end
        end
    end

    assign o_angle = r_c[NROT-1].zero ? '0 : r_c[NROT-1].acc;
    assign o_sb    = r_sb[NNORM+NROT-1];

endmodule

/* src/two_link_arm_inverse_kinematics.sv */
// Inverse kinematics for a two-link planar arm on a yawing base. Each request
// is a target (x, y, z) in signed Q8.8 with y the height; each result gives
// the base, shoulder and elbow angles in signed degrees Q.7, or reachable = 0
// with all angles 0 when the target lies beyond twice the link length. Link
// length and shoulder height come from two configuration registers (index 0
// mount height, index 1 link length); the user must write them only while
// the block is empty, as the block itself does not enforce it. The datapath
// is a fully pipelined chain: two front stages (squares, then distance sums
// and reach test), a 24-stage square root pipeline for r, d and the
// remaining reach, three parallel CORDIC lanes of 5 normalize stages plus
// CORDIC_STAGES rotation stages (capped at 24), a combine stage and an
// output register. A request enters every cycle while nothing stalls. Downstream
// back pressure stalls the whole pipeline at once, so nothing is lost or repeated.
module two_link_arm_inverse_kinematics #(
    parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    tlik_req_if.sink          i_req,
    tlik_res_if.source        o_res,
    tlik_cfg_if.sink          i_cfg
);

    localparam int SB_W = $bits(tlik_pkg::t_cord_sb);
    localparam int NIW  = tlik_pkg::NORM_IN_W;
    localparam int CBW  = tlik_pkg::COMB_W;

    // configuration
    logic [14:0] r_mount_height;
    logic [14:0] r_link_length;

    // pipeline advance: the output register is free or being drained
    logic w_en;

    // front to root
    tlik_pkg::t_root_sb                 w_front_sb;
    logic [tlik_pkg::ROOT_IN_W-1:0]     w_num_r;
    logic [tlik_pkg::ROOT_IN_W-1:0]     w_num_d;
    logic [tlik_pkg::ROOT_IN_W-1:0]     w_num_diff;

    // root to CORDIC
    tlik_pkg::t_root_sb                 w_root_sb;
    logic [tlik_pkg::ROOT_BITS-1:0]     w_root_r;
    logic [tlik_pkg::ROOT_BITS-1:0]     w_root_d;
    logic [tlik_pkg::ROOT_BITS-1:0]     w_root_diff;
    tlik_pkg::t_cord_sb                 w_cin_sb;

    // CORDIC outputs
    logic signed [tlik_pkg::ANG_W-1:0]  w_base;
    logic signed [tlik_pkg::ANG_W-1:0]  w_half;
    logic signed [tlik_pkg::ANG_W-1:0]  w_tilt;
    logic [SB_W-1:0]                    w_base_sb_raw;
    tlik_pkg::t_cord_sb                 w_cout_sb;
    logic [0:0]                         w_half_sb_unused;
    logic [0:0]                         w_tilt_sb_unused;

    // combine stage
    logic signed [CBW-1:0] n_cb_base;
    logic signed [CBW-1:0] n_cb_sh;
    logic signed [CBW-1:0] n_cb_el;
    logic signed [CBW-1:0] w_alpha;
    logic signed [CBW-1:0] w_beta;
    logic                  r_cb_valid;
    logic                  r_cb_reach;
    logic signed [CBW-1:0] r_cb_base;
    logic signed [CBW-1:0] r_cb_sh;
    logic signed [CBW-1:0] r_cb_el;

    // output stage
    logic signed [15:0]    w_q_base;
    logic signed [15:0]    w_q_sh;
    logic signed [15:0]    w_q_el;
    logic                  r_out_valid;
    logic                  r_out_reach;
    logic signed [14:0]    r_out_base;
    logic signed [15:0]    r_out_sh;
    logic signed [15:0]    r_out_el;

    // ---------------------------------------------------------------------
    // Configuration registers: always ready, unknown indexes are dropped
    // ---------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mount_height <= tlik_pkg::MOUNT_HEIGHT_RESET;
            r_link_length  <= tlik_pkg::LINK_LENGTH_RESET;
        end else if (i_cfg.valid) begin
            case (tlik_pkg::t_cfg_reg'(i_cfg.index))
                tlik_pkg::REG_MOUNT_HEIGHT: r_mount_height <= i_cfg.data;
                tlik_pkg::REG_LINK_LENGTH:  r_link_length  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Flow control: one enable for every stage
    // ---------------------------------------------------------------------
    assign w_en        = !r_out_valid || o_res.ready;
    assign i_req.ready = w_en;

    // ---------------------------------------------------------------------
    // Front: squares, distances, reach test
    // ---------------------------------------------------------------------
    tlik_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_req.valid),
        .i_x            (i_req.target_x),
        .i_y            (i_req.target_y),
        .i_z            (i_req.target_z),
        .i_mount_height (r_mount_height),
        .i_link_length  (r_link_length),
        .o_sb           (w_front_sb),
        .o_num_r        (w_num_r),
        .o_num_d        (w_num_d),
        .o_num_diff     (w_num_diff)
    );

    // ---------------------------------------------------------------------
    // Square roots of r^2, d^2 and 4L^2 - d^2, all in Q8.16
    // ---------------------------------------------------------------------
    tlik_root u_root (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_sb        (w_front_sb),
        .i_num_r     (w_num_r),
        .i_num_d     (w_num_d),
        .i_num_diff  (w_num_diff),
        .o_sb        (w_root_sb),
        .o_root_r    (w_root_r),
        .o_root_d    (w_root_d),
        .o_root_diff (w_root_diff)
    );

    // ---------------------------------------------------------------------
    // Three arctangent lanes of equal latency; the base lane carries the
    // request's valid, side and reach bits
    // ---------------------------------------------------------------------
    always_comb begin
        w_cin_sb.valid = w_root_sb.valid;
        w_cin_sb.neg   = w_root_sb.neg;
        w_cin_sb.reach = w_root_sb.reach;
    end

    tlik_cordic #(
        .STAGES (CORDIC_STAGES),
        .SB_W   (SB_W)
    ) u_cordic_base (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_x     (NIW'(w_root_sb.bx)),
        .i_y     (NIW'(w_root_sb.bz)),
        .i_sb    (w_cin_sb),
        .o_angle (w_base),
        .o_sb    (w_base_sb_raw)
    );

    // half elbow angle: atan2(d, sqrt(4L^2 - d^2))
    tlik_cordic #(
        .STAGES (CORDIC_STAGES),
        .SB_W   (1)
    ) u_cordic_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_x     ($signed({2'b00, w_root_diff})),
        .i_y     ($signed({2'b00, w_root_d})),
        .i_sb    (1'b0),
        .o_angle (w_half),
        .o_sb    (w_half_sb_unused)
    );

    // tilt of the target line: atan2(h, r)
    tlik_cordic #(
        .STAGES (CORDIC_STAGES),
        .SB_W   (1)
    ) u_cordic_tilt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_x     ($signed({2'b00, w_root_r})),
        .i_y     ($signed({w_root_sb.h[16], w_root_sb.h, 8'h00})),
        .i_sb    (1'b0),
        .o_angle (w_tilt),
        .o_sb    (w_tilt_sb_unused)
    );

    assign w_cout_sb = tlik_pkg::t_cord_sb'(w_base_sb_raw);

    // ---------------------------------------------------------------------
    // Combine: beta = 180 - 2*half, alpha = half - tilt, mirror for x < 0
    // ---------------------------------------------------------------------
    always_comb begin
        w_beta  = tlik_pkg::DEG180_Q16 - (CBW'(w_half) <<< 1);
        w_alpha = CBW'(w_half) - CBW'(w_tilt);
        if (w_cout_sb.neg) begin
            w_beta  = -w_beta;
            w_alpha = -w_alpha;
        end
        n_cb_base = -CBW'(w_base);
        n_cb_sh   = -w_alpha;
        n_cb_el   = -w_beta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb_valid <= 1'b0;
        end else if (w_en) begin
            r_cb_valid <= w_cout_sb.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cb_reach <= w_cout_sb.reach;
            r_cb_base  <= n_cb_base;
            r_cb_sh    <= n_cb_sh;
            r_cb_el    <= n_cb_el;
        end
    end

    // ---------------------------------------------------------------------
    // Output register: round to Q.7, clamp, zero out unreachable targets
    // ---------------------------------------------------------------------
    always_comb begin
        w_q_base = tlik_pkg::to_q7(r_cb_base, tlik_pkg::LIM_BASE);
        w_q_sh   = tlik_pkg::to_q7(r_cb_sh, tlik_pkg::LIM_JOINT);
        w_q_el   = tlik_pkg::to_q7(r_cb_el, tlik_pkg::LIM_JOINT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_cb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_reach <= r_cb_reach;
            r_out_base  <= r_cb_reach ? w_q_base[14:0] : 15'sd0;
            r_out_sh    <= r_cb_reach ? w_q_sh : 16'sd0;
            r_out_el    <= r_cb_reach ? w_q_el : 16'sd0;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.reachable      = r_out_reach;
    assign o_res.base_angle     = r_out_base;
    assign o_res.shoulder_angle = r_out_sh;
    assign o_res.elbow_angle    = r_out_el;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.reachable) |->
            (o_res.base_angle == 15'sd0 && o_res.shoulder_angle == 16'sd0 &&
             o_res.elbow_angle == 16'sd0))
        else $error("unreachable result carries nonzero angles");

    a_ready_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready == (!o_res.valid || o_res.ready))
        else $error("request ready does not follow output drain");

    a_base_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |->
            (o_res.base_angle <= 15'sd11520 && o_res.base_angle >= -15'sd11520))
        else $error("base angle outside clamp range");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int STAGES     = tlik_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY    = 33 + STAGES;
    localparam int IDLE_LIMIT = 4000;
    localparam int N_RANDOM   = 900;

    typedef struct {
        logic               reachable;
        logic signed [14:0] base_angle;
        logic signed [15:0] shoulder_angle;
        logic signed [15:0] elbow_angle;
    } t_angles;

    // one row of the directed table; has_exp marks rows whose result is typed in
    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 has_exp;
        t_angles            exp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tlik_req_if req_if ();
    tlik_res_if res_if ();
    tlik_cfg_if cfg_if ();

    two_link_arm_inverse_kinematics #(.CORDIC_STAGES(STAGES)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Shadow copy of the two registers, the way the block should hold them.
    logic [14:0] shadow_height;
    logic [14:0] shadow_link;

    t_angles angles_due[$];
    int      error_count;
    int      idle_cycles;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: fixed-point arm solver
    // ------------------------------------------------------------------

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // vectoring rotation, returns atan2(ya, xa) in Q.16 degrees for xa >= 0
    function automatic longint vector_angle(longint xa, longint ya);
        longint acc;
        longint dx;
        longint dy;
        int     n;
        acc = 0;
        if (xa == 0 && ya == 0) return 0;
        while ((xa < 0 ? -xa : xa) < (64'sd1 <<< 28) &&
               (ya < 0 ? -ya : ya) < (64'sd1 <<< 28)) begin
            xa = xa * 2;
            ya = ya * 2;
        end
        n = (STAGES > tlik_pkg::TABLE_LEN) ? tlik_pkg::TABLE_LEN : STAGES;
        for (int i = 0; i < n; i++) begin
            dx = floor_shr(ya, i);
            dy = floor_shr(xa, i);
            if (ya >= 0) begin
                xa  = xa + dx;
                ya  = ya - dy;
                acc = acc + longint'(tlik_pkg::atan_q16(i));
            end else begin
                xa  = xa - dx;
                ya  = ya + dy;
                acc = acc - longint'(tlik_pkg::atan_q16(i));
            end
        end
        return acc;
    endfunction

    function automatic longint round_q7(longint v16, longint lim);
        longint r;
        r = floor_shr(v16 + 256, 9);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic t_angles solve_arm(logic signed [15:0] tx, logic signed [15:0] ty,
                                          logic signed [15:0] tz);
        t_angles         res;
        longint          x;
        longint          y;
        longint          z;
        longint          h;
        longint          r2;
        longint          base16;
        longint          half16;
        longint          tilt16;
        longint          alpha16;
        longint          beta16;
        longint unsigned d2;
        longint unsigned reach2;
        bit              neg;
        x = tx;
        y = ty;
        z = tz;
        // a zero x stands for the smallest positive value
        if (x == 0) x = 1;
        neg    = x < 0;
        h      = y - longint'(shadow_height);
        r2     = x * x + z * z;
        d2     = r2 + h * h;
        reach2 = 4 * longint'(shadow_link) * longint'(shadow_link);
        res    = '{1'b0, '0, '0, '0};
        if (d2 > reach2) return res;
        base16  = -vector_angle(neg ? -x : x, neg ? -z : z);
        half16  = vector_angle(longint'(floor_sqrt((reach2 - d2) << 16)),
                               longint'(floor_sqrt(d2 << 16)));
        tilt16  = vector_angle(longint'(floor_sqrt(r2 << 16)), h * 256);
        beta16  = 64'sd11796480 - 2 * half16;
        alpha16 = half16 - tilt16;
        if (neg) begin
            beta16  = -beta16;
            alpha16 = -alpha16;
        end
        res.reachable      = 1'b1;
        res.base_angle     = 15'(round_q7(base16, 11520));
        res.shoulder_angle = 16'(round_q7(-alpha16, 23040));
        res.elbow_angle    = 16'(round_q7(-beta16, 23040));
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        error_count++;
    endtask

    // Sink side: random stall per result, compare each accepted result in order.
    initial begin
        t_angles want;
        int      stall;
        res_if.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk iff res_if.valid);
            if (angles_due.size() == 0) begin
                report_mismatch("unexpected result count", 1, 0);
            end else begin
                want = angles_due.pop_front();
                if (res_if.reachable !== want.reachable)
                    report_mismatch("reachable", res_if.reachable, want.reachable);
                if (res_if.base_angle !== want.base_angle)
                    report_mismatch("base_angle", res_if.base_angle, want.base_angle);
                if (res_if.shoulder_angle !== want.shoulder_angle)
                    report_mismatch("shoulder_angle", res_if.shoulder_angle,
                                    want.shoulder_angle);
                if (res_if.elbow_angle !== want.elbow_angle)
                    report_mismatch("elbow_angle", res_if.elbow_angle, want.elbow_angle);
            end
        end
    end

    // Watchdog: count cycles without any handshake on any channel.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Push one target; expected result comes from the table row or the predictor.
    // Valid stays high after the handshake so the next target can follow at once.
    task automatic send_target(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z, bit has_exp, t_angles exp_val);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.target_x <= x;
        req_if.target_y <= y;
        req_if.target_z <= z;
        @(posedge i_clk iff req_if.ready);
        angles_due.push_back(has_exp ? exp_val : solve_arm(x, y, z));
    endtask

    // Drop the request, drain every outstanding result, then let the pipeline settle.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(tlik_pkg::t_cfg_reg idx, logic [14:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk iff cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == tlik_pkg::REG_MOUNT_HEIGHT) shadow_height = value;
        else shadow_link = value;
        @(posedge i_clk);
    endtask

    // Mostly targets near the working envelope, so the reach test often passes,
    // with full-range noise mixed in (only noise once twice the link exceeds 23000).
    task automatic send_random(int count);
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        int                 span;
        t_angles            none;
        none = '{1'b0, '0, '0, '0};
        for (int i = 0; i < count; i++) begin
            span = 2 * int'(shadow_link);
            if ($urandom_range(0, 4) == 0 || span > 23000) begin
                x = 16'($urandom);
                y = 16'($urandom);
                z = 16'($urandom);
            end else begin
                x = 16'($signed($urandom_range(0, 2 * span)) - span);
                y = 16'($signed($urandom_range(0, 2 * span)) - span + int'(shadow_height));
                z = 16'($signed($urandom_range(0, 2 * span)) - span);
                if ($urandom_range(0, 15) == 0) x = '0;
            end
            send_target(x, y, z, 1'b0, none);
        end
    endtask

    t_row directed[] = '{
        // out of reach: everything zero
        '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1, '{1'b0, '0, '0, '0}},
        '{-16'sh8000, -16'sh8000, -16'sh8000, 1'b1, '{1'b0, '0, '0, '0}},
        '{16'sh7fff, 16'sd512, 16'sd0, 1'b1, '{1'b0, '0, '0, '0}},
        '{16'sd0, -16'sh8000, 16'sd0, 1'b1, '{1'b0, '0, '0, '0}},
        // zero x, on the shoulder, straight up, at full reach, mirrored
        '{16'sd0, 16'sd512, 16'sd0, 1'b0, '{1'b0, '0, '0, '0}},
        '{16'sd0, 16'sd768, 16'sd256, 1'b0, '{1'b0, '0, '0, '0}},
        '{16'sd0, 16'sd3072, 16'sd0, 1'b0, '{1'b0, '0, '0, '0}},
        '{16'sd2560, 16'sd512, 16'sd0, 1'b0, '{1'b0, '0, '0, '0}},
        '{-16'sd2560, 16'sd512, 16'sd0, 1'b0, '{1'b0, '0, '0, '0}},
        '{16'sd1536, 16'sd512, 16'sd2048, 1'b0, '{1'b0, '0, '0, '0}},
        '{16'sd1024, 16'sd1024, 16'sd256, 1'b0, '{1'b0, '0, '0, '0}},
        '{-16'sd1024, 16'sd1024, -16'sd256, 1'b0, '{1'b0, '0, '0, '0}},
        '{-16'sd1, 16'sd0, 16'sd1, 1'b0, '{1'b0, '0, '0, '0}},
        '{16'sd1, -16'sd1024, -16'sd1, 1'b0, '{1'b0, '0, '0, '0}},
        '{16'sd300, 16'sd300, -16'sd2000, 1'b0, '{1'b0, '0, '0, '0}},
        '{-16'sd300, -16'sd300, 16'sd2000, 1'b0, '{1'b0, '0, '0, '0}}
    };

    initial begin
        error_count     = 0;
        idle_cycles     = 0;
        shadow_height   = tlik_pkg::MOUNT_HEIGHT_RESET;
        shadow_link     = tlik_pkg::LINK_LENGTH_RESET;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.target_x = '0;
        req_if.target_y = '0;
        req_if.target_z = '0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = tlik_pkg::REG_MOUNT_HEIGHT;
        cfg_if.data     = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table under reset values of the registers
        foreach (directed[k])
            send_target(directed[k].x, directed[k].y, directed[k].z,
                        directed[k].has_exp, directed[k].exp);
        send_random(150);
        // hold the sender until the pipe is empty
        wait_drained();

        // smallest link: almost nothing is reachable
        write_reg(tlik_pkg::REG_LINK_LENGTH, 15'd1);
        write_reg(tlik_pkg::REG_MOUNT_HEIGHT, 15'd0);
        send_target(16'sd0, 16'sd0, 16'sd0, 1'b0, '{1'b0, '0, '0, '0});
        send_target(16'sd1, 16'sd1, 16'sd0, 1'b0, '{1'b0, '0, '0, '0});
        send_random(100);
        wait_drained();

        // largest values of both registers: full-range targets only
        write_reg(tlik_pkg::REG_LINK_LENGTH, 15'h7fff);
        write_reg(tlik_pkg::REG_MOUNT_HEIGHT, 15'h7fff);
        send_random(200);
        wait_drained();

        // mid settings
        write_reg(tlik_pkg::REG_LINK_LENGTH, 15'd640);
        write_reg(tlik_pkg::REG_MOUNT_HEIGHT, 15'd100);
        send_random(250);
        wait_drained();

        write_reg(tlik_pkg::REG_LINK_LENGTH, 15'd4000);
        write_reg(tlik_pkg::REG_MOUNT_HEIGHT, 15'd3000);
        send_random(200);

        wait_drained();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
